FILE: hw/rtl/rfc_pkg.sv
// shared types and constants for the received frame classifier
package rfc_pkg;

    // default configuration of the frame layout
    localparam int PREFIX_BYTES_DEF    = 4;
    localparam int MAX_FRAME_BYTES_DEF = 2048;

    // widths of the item fields
    localparam int BYTE_W   = 8;
    localparam int POS_W    = 12;
    localparam int IP_W     = 32;
    localparam int SUM_W    = 16;
    localparam int HWORDS_W = 4;
    localparam int FLAGS_W  = 8;
    localparam int M_DATA_W = 24;

    // byte offsets after the prefix, the ip and arp ones from the l3 start
    localparam int ETYPE_LO_OFS  = 12;
    localparam int ETYPE_HI_OFS  = 13;
    localparam int L3_OFS        = 14;
    localparam int IP_PROTO_OFS  = 9;
    localparam int IP_DST_FIRST  = 16;
    localparam int IP_DST_LAST   = 19;
    localparam int ARP_OP_LO_OFS = 6;
    localparam int ARP_OP_HI_OFS = 7;
    localparam int ARP_TPA_FIRST = 24;
    localparam int ARP_TPA_LAST  = 27;

    // field codes, multi-byte fields held in wire order (first byte low)
    localparam logic [15:0] ETYPE_ARP         = 16'h0608;
    localparam logic [15:0] ETYPE_IPV4        = 16'h0008;
    localparam logic [15:0] ARP_OP_REQUEST    = 16'h0100;
    localparam logic [15:0] ARP_OP_REPLY      = 16'h0200;
    localparam logic [7:0]  IP_PROTO_ICMP     = 8'h01;
    localparam logic [7:0]  IP_PROTO_UDP      = 8'h11;
    localparam logic [7:0]  ICMP_ECHO_REQUEST = 8'h08;
    localparam logic [7:0]  ICMP_ECHO_REPLY   = 8'h00;
    localparam logic [15:0] SUM_GOOD          = 16'hFFFF;

    // one bit per captured field of the current frame
    typedef struct packed {
        logic sum;
        logic dst_ip;
        logic arp_ip;
        logic opcode;
        logic icmp;
        logic proto;
        logic hlen;
        logic etype;
    } seen_t;

    // classification flags of one frame, lowest bit first in tdata
    typedef struct packed {
        logic ip_unicast;
        logic is_udp;
        logic echo_reply;
        logic echo_request;
        logic is_ipv4;
        logic arp_reply;
        logic arp_request;
        logic is_arp;
    } flags_t;

endpackage

FILE: hw/rtl/rx_frame_classifier_top.sv
// byte-serial classifier for received ethernet frames (arp, ipv4, icmp echo, udp)
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata[7:0] frame_byte, s_tlast last_byte
//  m_      | out | m_tvalid/m_tready  | m_tdata flags[7:0], frame_length[19:8]
//  cfg     | in  | local_ip_we        | local_ip_wdata[31:0] local_ip
//
// one byte item is taken per cycle; the frame state updates at the accepting edge
// and the result of a last byte is written into the output register at that same edge.
// the output register holds one result; while it is full and not taken, the input
// stalls. synchronous active-low reset clears frame state, local_ip and m_tvalid.
module rx_frame_classifier_top #(
    parameter int PREFIX_BYTES    = rfc_pkg::PREFIX_BYTES_DEF,
    parameter int MAX_FRAME_BYTES = rfc_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration
    input  logic                        local_ip_we,
    input  logic [rfc_pkg::IP_W-1:0]    local_ip_wdata,
    // byte input
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [rfc_pkg::BYTE_W-1:0]  s_tdata,   // [7:0] frame_byte
    input  logic                        s_tlast,   // last_byte
    // result output
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [rfc_pkg::M_DATA_W-1:0] m_tdata   // [0] is_arp, [1] arp_request,
                                                   // [2] arp_reply, [3] is_ipv4,
                                                   // [4] echo_request, [5] echo_reply,
                                                   // [6] is_udp, [7] ip_unicast,
                                                   // [19:8] frame_length, [23:20] zero
);

    localparam int POS_W = rfc_pkg::POS_W;
    localparam int CAP_INT = (MAX_FRAME_BYTES > 4095) ? 4095 : MAX_FRAME_BYTES;
    localparam logic [POS_W-1:0] POS_CAP   = POS_W'(CAP_INT);
    localparam logic [POS_W-1:0] POS_PRE   = POS_W'(PREFIX_BYTES);
    localparam logic [POS_W-1:0] POS_ET_LO = POS_W'(PREFIX_BYTES + rfc_pkg::ETYPE_LO_OFS);
    localparam logic [POS_W-1:0] POS_ET_HI = POS_W'(PREFIX_BYTES + rfc_pkg::ETYPE_HI_OFS);
    localparam logic [POS_W-1:0] POS_L3    = POS_W'(PREFIX_BYTES + rfc_pkg::L3_OFS);

    // frame state
    logic [POS_W-1:0]             pos_reg, pos_next;
    logic [rfc_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic [15:0]                  etype_reg, etype_next;
    logic [rfc_pkg::HWORDS_W-1:0] hwords_reg, hwords_next;
    logic [7:0]                   proto_reg, proto_next;
    logic [7:0]                   icmp_reg, icmp_next;
    logic [15:0]                  opcode_reg, opcode_next;
    logic                         arp_match_reg, arp_match_next;
    logic                         dst_match_reg, dst_match_next;
    rfc_pkg::seen_t               seen_reg, seen_next;
    logic [rfc_pkg::IP_W-1:0]     local_ip_reg;

    // result register
    logic                         m_valid_reg, m_valid_next;
    rfc_pkg::flags_t              flags_reg, flags_next;
    logic [POS_W-1:0]             len_reg, len_next;

    logic                         accept;
    logic [7:0]                   b;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign b        = s_tdata;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_ip_reg <= '0;
        end else if (local_ip_we) begin
            local_ip_reg <= local_ip_wdata;
        end
    end

    // decode of the accepted byte into the next frame state
    always_comb begin
        logic [POS_W-1:0] i;
        logic             in_l3;
        logic [3:0]       hw;
        logic             hlen_seen;
        logic [5:0]       hbytes;
        logic             in_sum;
        logic [15:0]      addend;
        logic [16:0]      s;
        logic [7:0]       octet;

        pos_next       = pos_reg;
        sum_next       = sum_reg;
        etype_next     = etype_reg;
        hwords_next    = hwords_reg;
        proto_next     = proto_reg;
        icmp_next      = icmp_reg;
        opcode_next    = opcode_reg;
        arp_match_next = arp_match_reg;
        dst_match_next = dst_match_reg;
        seen_next      = seen_reg;

        i         = pos_reg - POS_L3;
        in_l3     = (pos_reg >= POS_L3) && (pos_reg >= POS_PRE);
        hw        = (i == '0) ? b[3:0] : hwords_reg;
        hlen_seen = seen_reg.hlen || (i == '0);
        hbytes    = {hw, 2'b00};
        in_sum    = i < POS_W'(hbytes);
        addend    = i[0] ? {b, 8'h00} : {8'h00, b};
        s         = {1'b0, sum_reg} + {1'b0, addend};

        // local address octet for this byte, first octet in the top byte
        case (i[1:0])
            2'd0:    octet = local_ip_reg[31:24];
            2'd1:    octet = local_ip_reg[23:16];
            2'd2:    octet = local_ip_reg[15:8];
            default: octet = local_ip_reg[7:0];
        endcase

        if (accept && pos_reg < POS_CAP) begin
            pos_next = pos_reg + 1'b1;

            // ethertype
            if (pos_reg >= POS_PRE && pos_reg == POS_ET_LO) begin
                etype_next = {8'h00, b};
            end else if (pos_reg >= POS_PRE && pos_reg == POS_ET_HI) begin
                etype_next     = {b, etype_reg[7:0]};
                seen_next.etype = 1'b1;
            end

            if (in_l3) begin
                // ipv4 header length
                if (i == '0) begin
                    hwords_next    = b[3:0];
                    seen_next.hlen = 1'b1;
                end
                // ipv4 protocol
                if (i == POS_W'(rfc_pkg::IP_PROTO_OFS)) begin
                    proto_next      = b;
                    seen_next.proto = 1'b1;
                end
                // ipv4 destination address
                if (i >= POS_W'(rfc_pkg::IP_DST_FIRST) && i <= POS_W'(rfc_pkg::IP_DST_LAST)) begin
                    if (b != octet) begin
                        dst_match_next = 1'b0;
                    end
                    if (i == POS_W'(rfc_pkg::IP_DST_LAST)) begin
                        seen_next.dst_ip = 1'b1;
                    end
                end
                // header checksum and icmp type right after the header
                if (hlen_seen) begin
                    if (in_sum) begin
                        sum_next = s[15:0] + {15'd0, s[16]};
                        if (i + 1'b1 == POS_W'(hbytes)) begin
                            seen_next.sum = 1'b1;
                        end
                    end
                    if (i == POS_W'(hbytes)) begin
                        icmp_next      = b;
                        seen_next.icmp = 1'b1;
                    end
                end
                // arp opcode
                if (i == POS_W'(rfc_pkg::ARP_OP_LO_OFS)) begin
                    opcode_next = {8'h00, b};
                end else if (i == POS_W'(rfc_pkg::ARP_OP_HI_OFS)) begin
                    opcode_next      = {b, opcode_reg[7:0]};
                    seen_next.opcode = 1'b1;
                end
                // arp target address
                if (i >= POS_W'(rfc_pkg::ARP_TPA_FIRST) && i <= POS_W'(rfc_pkg::ARP_TPA_LAST)) begin
                    if (b != octet) begin
                        arp_match_next = 1'b0;
                    end
                    if (i == POS_W'(rfc_pkg::ARP_TPA_LAST)) begin
                        seen_next.arp_ip = 1'b1;
                    end
                end
            end
        end
    end

    // classification from the state including the current byte
    always_comb begin
        logic proto_ok;
        logic type_ok;

        proto_ok = seen_next.proto;
        type_ok  = seen_next.icmp;

        flags_next.is_arp = seen_next.etype && etype_next == rfc_pkg::ETYPE_ARP &&
                            seen_next.arp_ip && arp_match_next;
        flags_next.arp_request = flags_next.is_arp && seen_next.opcode &&
                                 opcode_next == rfc_pkg::ARP_OP_REQUEST;
        flags_next.arp_reply = flags_next.is_arp && !flags_next.arp_request &&
                               seen_next.opcode && opcode_next == rfc_pkg::ARP_OP_REPLY;
        flags_next.is_ipv4 = !flags_next.is_arp && seen_next.etype &&
                             etype_next == rfc_pkg::ETYPE_IPV4 &&
                             seen_next.sum && sum_next == rfc_pkg::SUM_GOOD;
        flags_next.echo_request = flags_next.is_ipv4 && proto_ok && type_ok &&
                                  proto_next == rfc_pkg::IP_PROTO_ICMP &&
                                  icmp_next == rfc_pkg::ICMP_ECHO_REQUEST;
        flags_next.echo_reply = flags_next.is_ipv4 && !flags_next.echo_request &&
                                proto_ok && type_ok &&
                                proto_next == rfc_pkg::IP_PROTO_ICMP &&
                                icmp_next == rfc_pkg::ICMP_ECHO_REPLY;
        flags_next.is_udp = flags_next.is_ipv4 && !flags_next.echo_request &&
                            !flags_next.echo_reply && proto_ok &&
                            proto_next == rfc_pkg::IP_PROTO_UDP;
        flags_next.ip_unicast = flags_next.is_ipv4 && seen_next.dst_ip && dst_match_next;

        len_next = pos_next;
    end

    // output handshake
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (accept && s_tlast) begin
            m_valid_next = 1'b1;
        end
    end

    // frame state registers, cleared by reset and after the last byte of a frame
    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_tlast)) begin
            pos_reg       <= '0;
            sum_reg       <= '0;
            etype_reg     <= '0;
            hwords_reg    <= '0;
            proto_reg     <= '0;
            icmp_reg      <= '0;
            opcode_reg    <= '0;
            arp_match_reg <= 1'b1;
            dst_match_reg <= 1'b1;
            seen_reg      <= '0;
        end else begin
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            etype_reg     <= etype_next;
            hwords_reg    <= hwords_next;
            proto_reg     <= proto_next;
            icmp_reg      <= icmp_next;
            opcode_reg    <= opcode_next;
            arp_match_reg <= arp_match_next;
            dst_match_reg <= dst_match_next;
            seen_reg      <= seen_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_tlast) begin
            flags_reg <= flags_next;
            len_reg   <= len_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'h0, len_reg, flags_reg};

endmodule
